// ===== rtl/acpu_pkg.sv =====
package acpu_pkg;

  // Field widths of the request and result words.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 12;
  localparam int OP_W   = 4;
  localparam int REQ_W  = 2;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EXEC  = 2'd2;

  // Instruction word layout.
  localparam int OP_LSB   = 27;
  localparam int ARG0_LSB = 15;
  localparam int ARG1_LSB = 3;

  // Opcodes; OP_NONE and every code not listed here are illegal and stop the core.
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 4'd1;
  localparam logic [OP_W-1:0] OP_SUB    = 4'd2;
  localparam logic [OP_W-1:0] OP_AND    = 4'd3;
  localparam logic [OP_W-1:0] OP_LSHIFT = 4'd4;
  localparam logic [OP_W-1:0] OP_ADDI   = 4'd5;
  localparam logic [OP_W-1:0] OP_READ   = 4'd6;
  localparam logic [OP_W-1:0] OP_WRITE  = 4'd7;
  localparam logic [OP_W-1:0] OP_JMP    = 4'd8;
  localparam logic [OP_W-1:0] OP_BIZ    = 4'd9;
  localparam logic [OP_W-1:0] OP_BNP    = 4'd10;
  localparam logic [OP_W-1:0] OP_HALT   = 4'd11;

  // Result of the shared ALU together with the flags that the branches test.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              is_zero;
    logic              is_neg;
  } alu_out_t;

endpackage

// ===== rtl/acpu_mem.sv =====
module acpu_mem #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  // Single-port word memory with a registered read.
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/acpu_amod.sv =====
module acpu_amod #(
  parameter int MEM_WORDS = 4096,
  localparam int AW = $clog2(MEM_WORDS)
) (
  input  logic                       clk,
  input  logic [acpu_pkg::ADDR_W-1:0] addr_in,
  output logic [AW-1:0]              addr_out
);

  import acpu_pkg::*;

  // Reduces a 12-bit address modulo MEM_WORDS in two pipeline stages: a
  // multiply by the rounded-up reciprocal gives the quotient, and a second
  // multiply and subtract give the remainder.
  localparam int RECIP_SH = 24;
  localparam logic [RECIP_SH-1:0] RECIP =
    RECIP_SH'((2**RECIP_SH + MEM_WORDS - 1) / MEM_WORDS);
  localparam int PROD_W = ADDR_W + RECIP_SH;
  localparam int DIFF_W = ADDR_W + 1;

  logic [ADDR_W-1:0] addr_s1_r;
  logic [PROD_W-1:0] prod_r;
  logic [ADDR_W-1:0] quot;
  logic [DIFF_W+ADDR_W-1:0] qm;
  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] rem;
  logic [AW-1:0]     addr_out_r;

  assign quot = prod_r[PROD_W-1:RECIP_SH];
  assign qm   = (DIFF_W+ADDR_W)'(quot) * (DIFF_W+ADDR_W)'(MEM_WORDS);
  assign diff = {1'b0, addr_s1_r} - qm[DIFF_W-1:0];

  always_comb begin
    if (diff >= DIFF_W'(MEM_WORDS)) begin
      rem = diff - DIFF_W'(MEM_WORDS);
    end else begin
      rem = diff;
    end
  end

  always_ff @(posedge clk) begin
    addr_s1_r  <= addr_in;
    prod_r     <= PROD_W'(addr_in) * PROD_W'(RECIP);
    addr_out_r <= rem[AW-1:0];
  end

  assign addr_out = addr_out_r;

endmodule

// ===== rtl/acpu_alu.sv =====
module acpu_alu (
  input  logic [acpu_pkg::OP_W-1:0]   op,
  input  logic [acpu_pkg::DATA_W-1:0] x,
  input  logic [acpu_pkg::DATA_W-1:0] y,
  input  logic [acpu_pkg::ADDR_W-1:0] imm,
  output acpu_pkg::alu_out_t          res
);

  import acpu_pkg::*;

  logic [DATA_W-1:0] value;

  // Loads and branches pass the first operand through.
  always_comb begin
    case (op)
      OP_ADD:    value = x + y;
      OP_SUB:    value = x - y;
      OP_AND:    value = x & y;
      OP_LSHIFT: value = x << y[4:0];
      OP_ADDI:   value = x + DATA_W'(imm);
      default:   value = x;
    endcase
  end

  assign res.value   = value;
  assign res.is_zero = (value == '0);
  assign res.is_neg  = value[DATA_W-1];

endmodule

// ===== rtl/accumulator_cpu_core.sv =====
module accumulator_cpu_core #(
  parameter int MEM_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mem_addr [11:0], mem_wdata [43:12], zero [47:44]
  input  logic [1:0]  in_tuser,   // req_type [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata   // read_word [31:0], prog_counter [43:32],
                                  // accumulator [75:44], opcode_run [79:76],
                                  // halted [80], illegal_op [81], zero [87:82]
);

  // Channel  | Direction | Carries
  // ---------+-----------+------------------------------------------------
  // in_      | slave     | one request: write word, read word or execute
  // out_     | master    | one result per request: word, PC, AC, status
  //
  // Every memory access goes through the two-stage address reducer and then
  // the single memory port with its registered read, one access after
  // another; an instruction makes up to three accesses (fetch plus two
  // operand reads).
  // Reset clears PC, AC and the halt and illegal flags; memory contents are
  // undefined until written. A finished result sits in the output register,
  // so the next request is accepted while it waits; a second result waits
  // in the final state until the output register is free.

  import acpu_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGEN,
    ST_AWAIT,
    ST_MEM,
    ST_DATA,
    ST_EXEC,
    ST_FIN
  } state_t;

  // Which memory access the sequencer is working on.
  typedef enum logic [2:0] {
    PH_USER,
    PH_FETCH,
    PH_OP0,
    PH_OP1,
    PH_WB
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [ADDR_W-1:0] addr_in_r, addr_in_nxt;
  logic [DATA_W-1:0] wdata_r, wdata_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              halt_r, halt_nxt;
  logic              illegal_r, illegal_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ADDR_W-1:0] arg0_r, arg0_nxt;
  logic [ADDR_W-1:0] arg1_r, arg1_nxt;
  logic [DATA_W-1:0] x_r, x_nxt;
  logic [DATA_W-1:0] y_r, y_nxt;
  logic [DATA_W-1:0] rword_r, rword_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [87:0]       out_data_r, out_data_nxt;

  logic [ADDR_W-1:0] pc_inc;
  logic [ADDR_W-1:0] agen_addr;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;
  logic [OP_W-1:0]   fetch_op;
  alu_out_t          alu_res;

  assign pc_inc   = ADDR_W'(pc_r + ADDR_W'(1));
  assign fetch_op = mem_rdata[OP_LSB +: OP_W];

  // The address that the reducer works on follows the current access.
  always_comb begin
    case (phase_r)
      PH_USER:  agen_addr = addr_in_r;
      PH_FETCH: agen_addr = pc_r;
      PH_OP1:   agen_addr = arg1_r;
      default:  agen_addr = arg0_r;
    endcase
  end

  acpu_amod #(.MEM_WORDS(MEM_WORDS)) u_amod (
    .clk      (clk),
    .addr_in  (agen_addr),
    .addr_out (mem_addr)
  );

  assign mem_we    = (state_r == ST_MEM) &&
                     ((phase_r == PH_WB) || (phase_r == PH_USER && req_r == REQ_WRITE));
  assign mem_wdata = (phase_r == PH_WB) ? acc_r : wdata_r;

  acpu_mem #(.DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  acpu_alu u_alu (
    .op  (op_r),
    .x   (x_r),
    .y   (y_r),
    .imm (arg1_r),
    .res (alu_res)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    req_nxt       = req_r;
    addr_in_nxt   = addr_in_r;
    wdata_nxt     = wdata_r;
    pc_nxt        = pc_r;
    acc_nxt       = acc_r;
    halt_nxt      = halt_r;
    illegal_nxt   = illegal_r;
    op_nxt        = op_r;
    arg0_nxt      = arg0_r;
    arg1_nxt      = arg1_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    rword_nxt     = rword_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          req_nxt     = in_tuser;
          addr_in_nxt = in_tdata[ADDR_W-1:0];
          wdata_nxt   = in_tdata[ADDR_W +: DATA_W];
          rword_nxt   = '0;
          op_nxt      = OP_NONE;
          case (in_tuser) inside
            REQ_WRITE, REQ_READ: begin
              phase_nxt = PH_USER;
              state_nxt = ST_AGEN;
            end
            REQ_EXEC: begin
              // A halted core answers an execute request without running.
              if (halt_r) begin
                state_nxt = ST_FIN;
              end else begin
                phase_nxt = PH_FETCH;
                state_nxt = ST_AGEN;
              end
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      ST_AGEN: begin
        state_nxt = ST_AWAIT;
      end

      ST_AWAIT: begin
        state_nxt = ST_MEM;
      end

      ST_MEM: begin
        if (mem_we) begin
          if (phase_r == PH_WB) begin
            pc_nxt = pc_inc;
          end
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DATA;
        end
      end

      ST_DATA: begin
        case (phase_r)
          PH_USER: begin
            rword_nxt = mem_rdata;
            state_nxt = ST_FIN;
          end
          PH_FETCH: begin
            op_nxt   = fetch_op;
            arg0_nxt = mem_rdata[ARG0_LSB +: ADDR_W];
            arg1_nxt = mem_rdata[ARG1_LSB +: ADDR_W];
            case (fetch_op) inside
              OP_ADD, OP_SUB, OP_AND, OP_LSHIFT, OP_ADDI, OP_READ, OP_BIZ, OP_BNP: begin
                phase_nxt = PH_OP0;
                state_nxt = ST_AGEN;
              end
              OP_WRITE: begin
                phase_nxt = PH_WB;
                state_nxt = ST_AGEN;
              end
              OP_JMP: begin
                pc_nxt    = mem_rdata[ARG0_LSB +: ADDR_W];
                state_nxt = ST_FIN;
              end
              OP_HALT: begin
                halt_nxt  = 1'b1;
                state_nxt = ST_FIN;
              end
              default: begin
                halt_nxt    = 1'b1;
                illegal_nxt = 1'b1;
                state_nxt   = ST_FIN;
              end
            endcase
          end
          PH_OP0: begin
            x_nxt = mem_rdata;
            case (op_r) inside
              OP_ADD, OP_SUB, OP_AND, OP_LSHIFT: begin
                phase_nxt = PH_OP1;
                state_nxt = ST_AGEN;
              end
              default: begin
                state_nxt = ST_EXEC;
              end
            endcase
          end
          default: begin
            y_nxt     = mem_rdata;
            state_nxt = ST_EXEC;
          end
        endcase
      end

      ST_EXEC: begin
        acc_nxt = alu_res.value;
        case (op_r)
          OP_BIZ:  pc_nxt = alu_res.is_zero ? arg1_r : pc_inc;
          OP_BNP:  pc_nxt = alu_res.is_neg ? arg1_r : pc_inc;
          default: pc_nxt = pc_inc;
        endcase
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // The result moves into the output register once it is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, illegal_r, halt_r, op_r, acc_r, pc_r, rword_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_USER;
      pc_r        <= '0;
      acc_r       <= '0;
      halt_r      <= 1'b0;
      illegal_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pc_r        <= pc_nxt;
      acc_r       <= acc_nxt;
      halt_r      <= halt_nxt;
      illegal_r   <= illegal_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    addr_in_r  <= addr_in_nxt;
    wdata_r    <= wdata_nxt;
    op_r       <= op_nxt;
    arg0_r     <= arg0_nxt;
    arg1_r     <= arg1_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    rword_r    <= rword_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
